@@ rtl/core/bole_pkg.sv @@
// shared types and constants for the bounded ordered list engine
package bole_pkg;

  localparam int CapacityDef   = 16;
  localparam int ValueWidthDef = 32;
  localparam int FindChunk     = 16;

  localparam logic [2:0] ReqAppend = 3'd0;
  localparam logic [2:0] ReqRemove = 3'd1;
  localparam logic [2:0] ReqRead   = 3'd2;
  localparam logic [2:0] ReqFind   = 3'd3;
  localparam logic [2:0] ReqClear  = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  position_in;
    logic [31:0] value_in;
  } bole_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] value_out;
    logic [3:0]  position_out;
    logic [4:0]  count;
    logic        is_empty;
  } bole_rsp_t;

  typedef struct packed {
    logic append;
    logic remove;
    logic find;
    logic scan;
  } bole_cell_cmd_t;

endpackage

@@ rtl/core/bole_cell.sv @@
// one list cell: holds an entry and its find hit, shifts both from cells further along the chain
module bole_cell #(
  parameter int VALUE_WIDTH = bole_pkg::ValueWidthDef,
  parameter int CountWidth  = $clog2(bole_pkg::CapacityDef + 1),
  parameter int INDEX       = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bole_pkg::bole_cell_cmd_t cmd_i,
  input  logic [CountWidth-1:0]  count_i,
  input  logic [3:0]             pos_i,
  input  logic [VALUE_WIDTH-1:0] key_i,
  input  logic [VALUE_WIDTH-1:0] next_val_i,
  input  logic                   next_hit_i,
  output logic [VALUE_WIDTH-1:0] val_o,
  output logic                   hit_o
);
  import bole_pkg::*;

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   hit_q, hit_d;
  logic                   in_list;

  assign in_list = CountWidth'(INDEX) < count_i;

  always_comb begin
    val_d = val_q;
    if (cmd_i.append && (count_i == CountWidth'(INDEX))) begin
      val_d = key_i;
    end else if (cmd_i.remove && (INDEX >= int'(pos_i))) begin
      val_d = next_val_i;
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (cmd_i.find) begin
      hit_d = in_list && (val_q == key_i);
    end else if (cmd_i.scan) begin
      hit_d = next_hit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign val_o = val_q;
  assign hit_o = hit_q;

endmodule

@@ rtl/core/bounded_ordered_list_engine.sv @@
// top level of the bounded ordered list engine: cell chain, control and result register
// An ordered list of up to CAPACITY words held in a chain of cells. Append, remove, read
// and clear complete in the cycle of the transfer and the result is registered, so these
// requests can be accepted one per cycle while the output is not stalled. A find compares
// in all cells in the transfer cycle, then the hit flags shift one chunk (16 positions, or
// CAPACITY if smaller) per cycle while the head chunk is priority encoded; a find ends at
// the first chunk with a hit or at the last chunk, and no request is accepted until then.
module bounded_ordered_list_engine #(
  parameter int CAPACITY    = bole_pkg::CapacityDef,
  parameter int VALUE_WIDTH = bole_pkg::ValueWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bole_pkg::bole_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bole_pkg::bole_rsp_t out_data_o
);
  import bole_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int CH = (CAPACITY < FindChunk) ? CAPACITY : FindChunk;
  localparam int BW = $clog2(CAPACITY + CH + 1);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic           state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [BW-1:0]  base_q, base_d;
  logic           out_valid_q, out_valid_d;
  bole_rsp_t      out_data_q, out_data_d;
  bole_rsp_t      rsp;
  logic           load_rsp;

  bole_cell_cmd_t         cmd;
  logic [VALUE_WIDTH-1:0] key;
  logic [63:0]            key_w;
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]    cell_hit;

  logic           out_free, in_fire, full, pos_in_range;
  logic [IW+3:0]  pos_w;
  logic [IW-1:0]  rd_idx;
  logic [63:0]    rd_w;
  logic           scan_any, scan_last;
  logic [3:0]     scan_first;
  logic [BW:0]    fpos_sum;
  logic [CW+4:0]  cnt_w;

  assign key_w = 64'(in_data_i.value_in);
  assign key   = key_w[VALUE_WIDTH-1:0];

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] nv;
    logic                   nh;
    if (g + 1 < CAPACITY) begin : g_nv
      assign nv = cell_val[g+1];
    end else begin : g_nv_end
      assign nv = '0;
    end
    if (g + CH < CAPACITY) begin : g_nh
      assign nh = cell_hit[g+CH];
    end else begin : g_nh_end
      assign nh = 1'b0;
    end
    bole_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CountWidth  (CW),
      .INDEX       (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .count_i    (count_q),
      .pos_i      (in_data_i.position_in),
      .key_i      (key),
      .next_val_i (nv),
      .next_hit_i (nh),
      .val_o      (cell_val[g]),
      .hit_o      (cell_hit[g])
    );
  end

  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = (state_q != StIdle) || !out_free;
  assign in_fire      = in_valid_i && !in_stall_o;
  assign full         = count_q == CW'(CAPACITY);
  assign pos_in_range = (CW+4)'(in_data_i.position_in) < (CW+4)'(count_q);
  assign pos_w        = (IW+4)'(in_data_i.position_in);
  assign rd_idx       = pos_w[IW-1:0];
  assign rd_w         = 64'(cell_val[rd_idx]);

  // head chunk priority encode
  always_comb begin
    scan_first = '0;
    for (int i = CH - 1; i >= 0; i--) begin
      if (cell_hit[i]) begin
        scan_first = 4'(i);
      end
    end
  end

  assign scan_any  = |cell_hit[CH-1:0];
  assign scan_last = ((BW+1)'(base_q) + (BW+1)'(CH)) >= (BW+1)'(CAPACITY);
  assign fpos_sum  = (BW+1)'(base_q) + (BW+1)'(scan_first);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    cmd         = '0;
    rsp         = '0;
    load_rsp    = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          load_rsp = 1'b1;
          case (in_data_i.req_type)
            ReqAppend: begin
              if (!full) begin
                cmd.append = 1'b1;
                count_d    = count_q + CW'(1);
                rsp.ok     = 1'b1;
              end
            end
            ReqRemove: begin
              if (pos_in_range) begin
                cmd.remove = 1'b1;
                count_d    = count_q - CW'(1);
                rsp.ok     = 1'b1;
              end
            end
            ReqRead: begin
              if (pos_in_range) begin
                rsp.ok        = 1'b1;
                rsp.value_out = rd_w[31:0];
              end
            end
            ReqFind: begin
              cmd.find = 1'b1;
              base_d   = '0;
              state_d  = StScan;
              load_rsp = 1'b0;
            end
            ReqClear: begin
              count_d = '0;
              rsp.ok  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      StScan: begin
        if (out_free) begin
          if (scan_any) begin
            rsp.ok           = 1'b1;
            rsp.position_out = fpos_sum[3:0];
            load_rsp         = 1'b1;
            state_d          = StIdle;
          end else if (scan_last) begin
            load_rsp = 1'b1;
            state_d  = StIdle;
          end else begin
            cmd.scan = 1'b1;
            base_d   = base_q + BW'(CH);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    cnt_w        = (CW+5)'(count_d);
    rsp.count    = cnt_w[4:0];
    rsp.is_empty = count_d == '0;
    if (load_rsp) begin
      out_valid_d = 1'b1;
      out_data_d  = rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_scan_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> !out_valid_q)
    else $error("result register busy during find");

  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.req_type != ReqFind) |=> out_valid_q && (state_q == StIdle))
    else $error("missing result after transfer");

  a_scan_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> (BW+1)'(base_q) < (BW+1)'(CAPACITY))
    else $error("find scan past end of list");

endmodule

@@ dv/bounded_ordered_list_engine_tb.sv @@
// self-checking testbench for the bounded ordered list engine
module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  localparam logic [2:0] ReqBadLo = 3'd5;
  localparam logic [2:0] ReqBadHi = 3'd7;
  localparam int RandomItems = 1950;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  bole_req_t req_data = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  bole_rsp_t rsp_data;

  bole_req_t   pending_req[$];
  bole_rsp_t   expected_rsp[$];
  logic [31:0] list_vals[CapacityDef];
  int          list_len = 0;
  int          mismatches = 0;
  int          accepted_cnt = 0;
  int          checked_cnt = 0;
  int          type_seen[8];
  int          full_refusals = 0;
  int          find_hits = 0;

  bounded_ordered_list_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_data_o  (rsp_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("timed out with %0d results outstanding", expected_rsp.size());
    $display("FAIL");
    $finish;
  end

  function automatic bole_rsp_t predict_response(bole_req_t req);
    bole_rsp_t rsp;
    int idx;
    rsp = '0;
    case (req.req_type)
      ReqAppend: begin
        if (list_len < CapacityDef) begin
          list_vals[list_len] = req.value_in;
          list_len++;
          rsp.ok = 1'b1;
        end
      end
      ReqRemove: begin
        if (int'(req.position_in) < list_len) begin
          for (idx = int'(req.position_in); idx < list_len - 1; idx++)
            list_vals[idx] = list_vals[idx + 1];
          list_len--;
          rsp.ok = 1'b1;
        end
      end
      ReqRead: begin
        if (int'(req.position_in) < list_len) begin
          rsp.value_out = list_vals[req.position_in];
          rsp.ok = 1'b1;
        end
      end
      ReqFind: begin
        for (idx = 0; idx < list_len; idx++) begin
          if (!rsp.ok && list_vals[idx] == req.value_in) begin
            rsp.ok = 1'b1;
            rsp.position_out = 4'(idx);
          end
        end
      end
      ReqClear: begin
        list_len = 0;
        rsp.ok = 1'b1;
      end
      default: ;
    endcase
    rsp.count = 5'(list_len);
    rsp.is_empty = (list_len == 0);
    return rsp;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch on %s at result %0d: expected %h, got %h",
               what, checked_cnt, want, got);
  endtask

  task automatic compare_response(bole_rsp_t got, bole_rsp_t want);
    if (got.ok !== want.ok) flag_mismatch("ok", 32'(want.ok), 32'(got.ok));
    if (got.value_out !== want.value_out)
      flag_mismatch("value_out", want.value_out, got.value_out);
    if (got.position_out !== want.position_out)
      flag_mismatch("position_out", 32'(want.position_out), 32'(got.position_out));
    if (got.count !== want.count) flag_mismatch("count", 32'(want.count), 32'(got.count));
    if (got.is_empty !== want.is_empty)
      flag_mismatch("is_empty", 32'(want.is_empty), 32'(got.is_empty));
  endtask

  // random pauses, none in a window in the middle of the run
  function automatic bit take_a_break(int done);
    return (done < 700 || done >= 1000) && ($urandom_range(0, 99) < 18);
  endfunction

  task automatic queue_req(logic [2:0] kind, logic [3:0] pos, logic [31:0] val);
    bole_req_t req;
    req.req_type = kind;
    req.position_in = pos;
    req.value_in = val;
    pending_req.push_back(req);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    bole_rsp_t want;
    logic holding;
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      holding = req_valid;
      if (req_valid && !req_stall) begin
        want = predict_response(req_data);
        expected_rsp.push_back(want);
        type_seen[req_data.req_type]++;
        if (req_data.req_type == ReqAppend && !want.ok) full_refusals++;
        if (req_data.req_type == ReqFind && want.ok) find_hits++;
        accepted_cnt++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (pending_req.size() > 0 && !take_a_break(accepted_cnt)) begin
          req_data <= pending_req.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_responses
    if (!rst_ni) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) flag_mismatch("result with none pending", '0, '0);
        else compare_response(rsp_data, expected_rsp.pop_front());
        checked_cnt++;
      end
      rsp_stall <= take_a_break(checked_cnt);
    end
  end

  initial begin : stimulus
    logic [31:0] value_pool[8];
    int mode;
    int run_len;
    int roll;
    int queued;
    logic [2:0] kind;
    logic [3:0] pos;
    logic [31:0] val;

    value_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0BAD_CAFE};

    // empty list corner cases
    queue_req(ReqRead, 4'd0, 32'h0);
    queue_req(ReqFind, 4'd0, 32'h0);
    queue_req(ReqRemove, 4'd0, 32'h0);
    queue_req(ReqBadLo, 4'd0, 32'h0);
    // fill to capacity, then overflow, then reads, finds, removes and a clear
    for (int i = 0; i < CapacityDef; i++) queue_req(ReqAppend, 4'(i), 32'h1111_1111 * i);
    queue_req(ReqAppend, 4'd0, 32'hDEAD_BEEF);
    queue_req(ReqRead, 4'd15, 32'h0);
    queue_req(ReqFind, 4'd0, 32'hFFFF_FFFF);
    queue_req(ReqRemove, 4'd15, 32'h0);
    queue_req(ReqRead, 4'd15, 32'h0);
    queue_req(ReqRemove, 4'd0, 32'h0);
    queue_req(ReqFind, 4'd3, 32'h1234_5678);
    queue_req(ReqClear, 4'd9, 32'hFFFF_FFFF);

    queued = 0;
    while (queued < RandomItems) begin
      mode = $urandom_range(0, 2);
      run_len = $urandom_range(20, 60);
      repeat (run_len) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0: kind = (roll < 55) ? ReqAppend : (roll < 65) ? ReqRemove :
                    (roll < 80) ? ReqRead : (roll < 97) ? ReqFind : ReqBadLo;
          1: kind = (roll < 15) ? ReqAppend : (roll < 50) ? ReqRemove :
                    (roll < 70) ? ReqRead : (roll < 90) ? ReqFind :
                    (roll < 95) ? ReqClear : ReqBadLo;
          default: kind = (roll < 30) ? ReqAppend : (roll < 45) ? ReqRemove :
                          (roll < 65) ? ReqRead : (roll < 90) ? ReqFind :
                          (roll < 93) ? ReqClear : ReqBadLo;
        endcase
        if (kind == ReqBadLo) kind = 3'($urandom_range(ReqBadLo, ReqBadHi));
        pos = ($urandom_range(0, 99) < 30) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        val = ($urandom_range(0, 99) < 70) ? value_pool[$urandom_range(0, 7)] : $urandom();
        queue_req(kind, pos, val);
        queued++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_req.size() > 0 || req_valid || expected_rsp.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_rsp.size() != 0) flag_mismatch("results never returned", '0, '0);

    $display("requests: %0d append, %0d remove, %0d read, %0d find, %0d clear, %0d undefined",
             type_seen[ReqAppend], type_seen[ReqRemove], type_seen[ReqRead],
             type_seen[ReqFind], type_seen[ReqClear],
             type_seen[5] + type_seen[6] + type_seen[7]);
    $display("%0d results checked, %0d appends refused when full, %0d finds hit, %0d mismatches",
             checked_cnt, full_refusals, find_hits, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
